FILE: hdl/log_band_spectrum_peak_meter_defines.svh
// Assertion macros for the band peak meter.
`ifndef LOG_BAND_SPECTRUM_PEAK_METER_DEFINES_SVH
`define LOG_BAND_SPECTRUM_PEAK_METER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled in reset.
`define LBSPM_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lbspm: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define LBSPM_ASSERT_NXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lbspm: next-cycle check failed");

`else

`define LBSPM_ASSERT_IMP(name, clk, rstn, ante, cons)
`define LBSPM_ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

FILE: hdl/lbspm_pkg.sv
package lbspm_pkg;

    localparam int BANDS      = 20;
    localparam int BINS       = 1024;
    localparam int MAG_BITS   = 16;
    localparam int LEVEL_W    = 8;
    localparam int BAND_W     = 6;
    localparam int BAND_IDX_W = $clog2(BANDS);
    localparam int BIN_W      = $clog2(BINS);
    // 9 * m^2
    localparam int NINE_W     = 2 * LEVEL_W + 4;
    // 9 * m^2 * peak
    localparam int RHS_W      = NINE_W + MAG_BITS;
    localparam int SCALED_W   = 2 * LEVEL_W + MAG_BITS;
    localparam int STEP_W     = $clog2(LEVEL_W);

    localparam logic [LEVEL_W-1:0] FULL_SCALE_RESET = 8'd255;

    // Upper bin of each band: floor(2^(10x/19)), capped, strictly increasing
    localparam logic [BIN_W-1:0] BAND_EDGES [BANDS] = '{
        10'd1,   10'd2,   10'd3,   10'd4,   10'd5,
        10'd6,   10'd8,   10'd12,  10'd18,  10'd26,
        10'd38,  10'd55,  10'd79,  10'd114, 10'd165,
        10'd237, 10'd342, 10'd493, 10'd710, 10'd1023
    };

    typedef struct packed {
        logic [MAG_BITS-1:0] magnitude;
        logic                frame_start;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [BAND_W-1:0]  band_index;
        logic               last_band;
    } out_item_t;

    // band close request from tracker to level unit
    typedef struct packed {
        logic                start;
        logic [MAG_BITS-1:0] peak;
        logic [BAND_W-1:0]   band;
        logic                last;
    } band_close_t;

    // level unit status and result
    typedef struct packed {
        logic      busy;
        logic      valid;
        out_item_t item;
    } level_res_t;

    function automatic logic [BIN_W-1:0] band_edge(input logic [BAND_IDX_W-1:0] idx);
        logic [BIN_W-1:0] e;
        e = '0;
        if (int'(idx) < BANDS) begin
            e = BAND_EDGES[idx];
        end
        return e;
    endfunction

endpackage

FILE: hdl/lbspm_band_tracker.sv
module lbspm_band_tracker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  lbspm_pkg::in_item_t  item,
    output lbspm_pkg::band_close_t close
);
    import lbspm_pkg::*;

    logic [MAG_BITS-1:0] peak_reg, peak_next;
    logic [BIN_W-1:0]    bin_reg, bin_next;
    logic [BAND_W-1:0]   band_reg, band_next;

    logic                active;
    logic [BIN_W-1:0]    bin_inc;
    logic [MAG_BITS-1:0] peak_max;
    logic                hit;

    assign active   = int'(band_reg) < BANDS;
    assign bin_inc  = bin_reg + BIN_W'(1);
    assign peak_max = (item.magnitude > peak_reg) ? item.magnitude : peak_reg;
    assign hit      = active && (bin_inc == band_edge(band_reg[BAND_IDX_W-1:0]));

    always_comb begin
        peak_next   = peak_reg;
        bin_next    = bin_reg;
        band_next   = band_reg;
        close.start = 1'b0;
        close.peak  = peak_max;
        close.band  = band_reg;
        close.last  = (int'(band_reg) == BANDS - 1);
        if (accept) begin
            if (item.frame_start) begin
                peak_next = '0;
                bin_next  = '0;
                band_next = '0;
            end else if (active) begin
                // counter freezes once all bands are closed
                bin_next = bin_inc;
                if (hit) begin
                    close.start = 1'b1;
                    peak_next   = '0;
                    band_next   = band_reg + BAND_W'(1);
                end else begin
                    peak_next = peak_max;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg <= '0;
            bin_reg  <= '0;
            band_reg <= '0;
        end else begin
            peak_reg <= peak_next;
            bin_reg  <= bin_next;
            band_reg <= band_next;
        end
    end

endmodule

FILE: hdl/lbspm_level_unit.sv
module lbspm_level_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lbspm_pkg::band_close_t close,
    input  logic [lbspm_pkg::LEVEL_W-1:0] full_scale,
    input  logic                  take,
    output lbspm_pkg::level_res_t res
);
    import lbspm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SQUARE = 5'b00010,
        ST_RHS    = 5'b00100,
        ST_ITER   = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [MAG_BITS-1:0]  peak_reg;
    logic [BAND_W-1:0]    band_reg;
    logic                 last_reg;
    logic [2*LEVEL_W-1:0] msq_reg;
    logic [RHS_W-1:0]     rhs_reg;
    logic [LEVEL_W-1:0]   y_reg, y_next;
    logic [STEP_W-1:0]    step_reg;

    logic [LEVEL_W-1:0]   trial;
    logic [2*LEVEL_W-1:0] tsq;
    logic [SCALED_W-1:0]  scaled;
    logic [NINE_W-1:0]    nine_msq;
    logic                 fits;

    // trial*trial*(2^MAG_BITS - 1) by shift and subtract
    assign trial    = y_reg | (LEVEL_W'(1) << step_reg);
    assign tsq      = (2*LEVEL_W)'(trial) * (2*LEVEL_W)'(trial);
    assign scaled   = {tsq, MAG_BITS'(0)} - SCALED_W'(tsq);
    assign nine_msq = NINE_W'({msq_reg, 3'b000}) + NINE_W'(msq_reg);
    assign fits     = (trial <= full_scale) && (RHS_W'(scaled) <= rhs_reg);
    assign y_next   = fits ? trial : y_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (close.start) state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_RHS;
            ST_RHS:    state_next = ST_ITER;
            ST_ITER:   if (step_reg == '0) state_next = ST_DONE;
            ST_DONE:   if (take) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                peak_reg <= close.peak;
                band_reg <= close.band;
                last_reg <= close.last;
            end
            ST_SQUARE: begin
                msq_reg <= (2*LEVEL_W)'(full_scale) * (2*LEVEL_W)'(full_scale);
            end
            ST_RHS: begin
                rhs_reg  <= RHS_W'(nine_msq) * RHS_W'(peak_reg);
                y_reg    <= '0;
                step_reg <= STEP_W'(LEVEL_W - 1);
            end
            ST_ITER: begin
                y_reg    <= y_next;
                step_reg <= step_reg - STEP_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign res.busy            = (state_reg != ST_IDLE);
    assign res.valid           = (state_reg == ST_DONE);
    assign res.item.level      = y_reg;
    assign res.item.band_index = band_reg;
    assign res.item.last_band  = last_reg;

endmodule

FILE: hdl/log_band_spectrum_peak_meter.sv
// Log-spaced band peak meter for one FFT frame at a time.
// Input channel s_*: one bin magnitude per request, DC bin first with
// frame_start set; the DC bin is skipped and bins 1..1023 fall into 20
// log-spaced bands. Output channel m_*: one request per closed band with
// its level, band number and a last-band flag.
// A bin that does not close a band is taken and leaves s_ready high.
// A bin that closes a band starts the level unit, which works through
// full_scale squared, the 36-bit right-hand side, then 8 bit-set steps of
// the square root, each one 8x8 multiply and a compare. s_ready is low
// while the unit runs and while its result waits. The result moves to an
// output register once that is empty or read, so a stalled receiver also
// holds the unit and no bins are taken until the result has moved on.
// cfg_wr_en writes the full-scale level (reset 255) at once; write it only while idle.
// Reset (aresetn low, synchronous) clears the counters as if a DC bin was
// just seen and empties the output register.
`include "log_band_spectrum_peak_meter_defines.svh"

module log_band_spectrum_peak_meter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lbspm_pkg::in_item_t s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output lbspm_pkg::out_item_t m_payload,
    input  logic                cfg_wr_en,
    input  logic [lbspm_pkg::LEVEL_W-1:0] cfg_wr_data
);
    import lbspm_pkg::*;

    logic               accept;
    band_close_t        close;
    level_res_t         res;
    logic               take;
    logic [LEVEL_W-1:0] full_scale_reg;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_payload_reg;

    assign s_ready = !res.busy;
    assign accept  = s_valid && s_ready;
    assign take    = res.valid && (!m_valid_reg || m_ready);

    lbspm_band_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_payload),
        .close   (close)
    );

    lbspm_level_unit u_level (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .close      (close),
        .full_scale (full_scale_reg),
        .take       (take),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_scale_reg <= FULL_SCALE_RESET;
        end else if (cfg_wr_en) begin
            full_scale_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_payload_reg <= res.item;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    `LBSPM_ASSERT_IMP(a_start_when_idle, aclk, aresetn, close.start, !res.busy)
    `LBSPM_ASSERT_IMP(a_level_in_range, aclk, aresetn, m_valid, m_payload.level <= full_scale_reg)
    `LBSPM_ASSERT_IMP(a_last_flag, aclk, aresetn, m_valid, m_payload.last_band == (int'(m_payload.band_index) == BANDS - 1))
    `LBSPM_ASSERT_NXT(a_take_loads, aclk, aresetn, take, m_valid && !res.valid)

endmodule
